[rtl/svg_pkg.sv]
// Shared types and constants of the vertical Sobel gradient block.
`default_nettype none

package svg_pkg;

	// Payload widths
	localparam int PIXEL_W = 8;
	localparam int SUM_W   = PIXEL_W + 2;
	localparam int GRAD_W  = SUM_W + 1;
	localparam int INDEX_W = 20;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 11;
	localparam int ROW_W      = 10;
	localparam int START_W    = 20;

	// Register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd480;
	localparam logic [ROW_W-1:0]    ROW_RST    = 10'd1;
	localparam logic [START_W-1:0]  START_RST  = 20'd0;

	// Smallest legal frame edge
	localparam int MIN_EDGE = 3;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_FIRST_ROW    = 2'd2,
		REG_START_INDEX  = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

[rtl/svg_pix_if.sv]
// Pixel stream channel: valid, ready and one grey pixel.
`default_nettype none

interface svg_pix_if;
	import svg_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

[rtl/svg_res_if.sv]
// Result channel: valid, ready, gradient, output index and end-of-frame flag.
`default_nettype none

interface svg_res_if;
	import svg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] gradient;
	logic [INDEX_W-1:0]       out_index;
	logic                     frame_done;

	modport source (output valid, output gradient, output out_index, output frame_done,
		input ready);
	modport sink   (input valid, input gradient, input out_index, input frame_done,
		output ready);
endinterface

`default_nettype wire

[rtl/sobel_vertical_gradient_3x3.sv]
// Top level: 3x3 vertical Sobel gradient over a raster pixel stream.
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+-------------------------------------
//  pixels    | in  | valid / ready   | pixel[7:0]
//  results   | out | valid / ready   | gradient[10:0], out_index[19:0], frame_done
//  cfg       | in  | cfg_we          | cfg_index[1:0], cfg_data[19:0]
//
// One pixel per cycle sustained unless the output stalls; each result passes
// stage one and the output register. The rate is set by the single line memory
// port pair: one read at accept, one write-back as the pixel leaves stage one.
// Reset clears the configuration registers, counters, window and valid flags; the
// line memory is not cleared, so there is no clearing pass after reset.
// A stalled output register holds stage one, which in turn drops pixels.ready.
`default_nettype none

module sobel_vertical_gradient_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [svg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [svg_pkg::CFG_DATA_W-1:0]   cfg_data,
	svg_pix_if.sink                         pixels,
	svg_res_if.source                       results
);
	import svg_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int LW    = CW + RW;
	localparam int CMP_W = (LW > INDEX_W) ? LW : INDEX_W;

	// Clamp helpers for the frame geometry
	function automatic logic [WW-1:0] clamp_w(input logic [WIDTH_W-1:0] v);
		logic [WW-1:0] r;
		if (32'(v) < MIN_EDGE)
			r = WW'(MIN_EDGE);
		else if (32'(v) > MAX_WIDTH)
			r = WW'(MAX_WIDTH);
		else
			r = WW'(v);
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [HEIGHT_W-1:0] v);
		logic [HW-1:0] r;
		if (32'(v) < MIN_EDGE)
			r = HW'(MIN_EDGE);
		else if (32'(v) > MAX_HEIGHT)
			r = HW'(MAX_HEIGHT);
		else
			r = HW'(v);
		return r;
	endfunction

	// Configuration registers
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [ROW_W-1:0]    first_row_q;
	logic [START_W-1:0]  start_q;

	// Position state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [LW-1:0] row_base_q;   // row_q * effective width

	// Window: two older columns of the top and bottom rows
	logic [PIXEL_W-1:0] win_top_q [2];
	logic [PIXEL_W-1:0] win_bot_q [2];

	// Stage one
	logic                   valid_s1;
	logic [PIXEL_W-1:0]     px_s1;
	logic [CW-1:0]          col_s1;
	logic [LW-1:0]          idx_s1;
	logic                   geo_s1;
	logic                   last_s1;
	logic [2*PIXEL_W-1:0]   rd_s1;    // {row r-1, row r-2}

	// Output register
	logic                     out_valid_q;
	logic signed [GRAD_W-1:0] gradient_q;
	logic [INDEX_W-1:0]       out_index_q;
	logic                     frame_done_q;

	// Line memory: upper byte row r-1, lower byte row r-2
	logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];

	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [ROW_W-1:0] fr_eff;
	logic             col_last;
	logic             row_last;
	logic             geo_ok;
	logic             frame_end;
	logic             in_fire;
	logic             s1_adv;
	logic             pix_ready;
	logic [WW-1:0]    w_new;
	logic [RW+WW-1:0] base_prod;
	logic [SUM_W-1:0] top_sum;
	logic [SUM_W-1:0] bot_sum;
	logic signed [GRAD_W-1:0] grad;
	logic [LW-1:0]    center_idx;
	logic [LW-1:0]    result_idx;
	logic             start_ok;
	logic             produce;

	// Effective geometry and position decode
	always_comb begin
		w_eff     = clamp_w(width_q);
		h_eff     = clamp_h(height_q);
		fr_eff    = (first_row_q == '0) ? ROW_W'(1) : first_row_q;
		col_last  = 32'(col_q) >= 32'(w_eff) - 32'd1;
		row_last  = 32'(row_q) >= 32'(h_eff) - 32'd1;
		frame_end = (32'(col_q) == 32'(w_eff) - 32'd1) && (32'(row_q) == 32'(h_eff) - 32'd1);
		geo_ok    = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2)
			&& (32'(row_q) <= 32'(h_eff) - 32'd1) && (32'(col_q) <= 32'(w_eff) - 32'd1)
			&& (32'(row_q) >= 32'(fr_eff) + 32'd1);
		w_new     = clamp_w(cfg_data[WIDTH_W-1:0]);
		base_prod = row_q * w_new;
	end

	// Handshake
	assign s1_adv    = valid_s1 && (!out_valid_q || results.ready);
	assign pix_ready = !valid_s1 || s1_adv;
	assign in_fire   = pixels.valid && pix_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			first_row_q <= ROW_RST;
			start_q     <= START_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q     <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_data[HEIGHT_W-1:0];
				REG_FIRST_ROW:    first_row_q <= cfg_data[ROW_W-1:0];
				REG_START_INDEX:  start_q     <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	// Column and row counters, running row base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (cfg_we && cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH) begin
			row_base_q <= LW'(base_prod);
		end else if (in_fire) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q      <= '0;
					row_base_q <= '0;
				end else begin
					row_q      <= row_q + RW'(1);
					row_base_q <= row_base_q + LW'(w_eff);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line memory: read at accept, write back as stage one moves on
	always_ff @(posedge clk) begin
		if (in_fire)
			rd_s1 <= line_mem[col_q];
		if (s1_adv)
			line_mem[col_s1] <= {px_s1, rd_s1[2*PIXEL_W-1:PIXEL_W]};
	end

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1   <= pixels.pixel;
			col_s1  <= col_q;
			idx_s1  <= row_base_q + LW'(col_q);
			geo_s1  <= geo_ok;
			last_s1 <= frame_end;
		end
	end

	// Gradient and index of the window centered one row and column back
	always_comb begin
		top_sum    = SUM_W'(win_top_q[0]) + {1'b0, win_top_q[1], 1'b0}
			+ SUM_W'(rd_s1[PIXEL_W-1:0]);
		bot_sum    = SUM_W'(win_bot_q[0]) + {1'b0, win_bot_q[1], 1'b0} + SUM_W'(px_s1);
		grad       = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
		center_idx = idx_s1 - LW'(w_eff) - LW'(1);
		result_idx = idx_s1 - LW'(w_eff) - LW'(w_eff) - LW'(2);
		start_ok   = CMP_W'(center_idx) >= CMP_W'(start_q);
		produce    = geo_s1 && start_ok;
	end

	// Window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_top_q[0] <= '0;
			win_top_q[1] <= '0;
			win_bot_q[0] <= '0;
			win_bot_q[1] <= '0;
		end else if (s1_adv) begin
			win_top_q[0] <= win_top_q[1];
			win_top_q[1] <= rd_s1[PIXEL_W-1:0];
			win_bot_q[0] <= win_bot_q[1];
			win_bot_q[1] <= px_s1;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= produce;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_adv && produce) begin
			gradient_q   <= grad;
			out_index_q  <= INDEX_W'(result_idx);
			frame_done_q <= last_s1;
		end
	end

	assign pixels.ready       = pix_ready;
	assign results.valid      = out_valid_q;
	assign results.gradient   = gradient_q;
	assign results.out_index  = out_index_q;
	assign results.frame_done = frame_done_q;

	// Checks
	a_fire_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted pixel did not reach stage one");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pixels.ready)
		else $error("empty pipeline refuses pixels");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !results.ready |=> valid_s1 && $stable(col_s1))
		else $error("stage one moved while output stalled");

	a_produce_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && produce |=> out_valid_q)
		else $error("result lost on its way to the output register");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the 3x3 vertical Sobel gradient block.
`timescale 1ns / 1ps

module tb;
	import svg_pkg::*;

	localparam int MAX_COLS      = 1024;
	localparam int MAX_ROWS      = 1024;
	localparam int CENTER_WEIGHT = 2;
	localparam int IDLE_PCT      = 7;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 740;
	localparam int LIMIT_CYCLES  = 400000;

	// Pixel patterns for frame fill
	typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_STRIPE} pix_pattern_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic [INDEX_W-1:0]       out_index;
		logic                     frame_done;
	} grad_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	svg_pix_if pix_ch ();
	svg_res_if res_ch ();

	// Gradient predictor state: registers, line copies, window, raster position
	int unsigned        width_reg, height_reg, first_row_reg, start_reg;
	logic [PIXEL_W-1:0] line_prev  [MAX_COLS];
	logic [PIXEL_W-1:0] line_prev2 [MAX_COLS];
	logic [PIXEL_W-1:0] window_px  [9];
	int unsigned        col_pos, row_pos;

	grad_result_t expected_results [$];
	int unsigned  items_sent;
	int unsigned  errors;
	int unsigned  cycle_count;
	int unsigned  hold_request;
	int unsigned  hold_left;
	bit           steady;

	sobel_vertical_gradient_3x3 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.results   (res_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t timeout with %0d results outstanding", $time, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: check each transaction, then pick ready for the next cycle
	always @(posedge clk) begin
		grad_result_t got, want;
		if (res_ch.valid && res_ch.ready) begin
			got = '{res_ch.gradient, res_ch.out_index, res_ch.frame_done};
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: actual gradient %0d index %0d done %0b",
					$time, $signed(got.gradient), got.out_index, got.frame_done);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.gradient !== want.gradient) begin
					$display("%0t gradient mismatch: expected %0d, actual %0d",
						$time, $signed(want.gradient), $signed(got.gradient));
					errors++;
				end
				if (got.out_index !== want.out_index) begin
					$display("%0t out_index mismatch: expected %0d, actual %0d",
						$time, want.out_index, got.out_index);
					errors++;
				end
				if (got.frame_done !== want.frame_done) begin
					$display("%0t frame_done mismatch: expected %0b, actual %0b",
						$time, want.frame_done, got.frame_done);
					errors++;
				end
			end
		end
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (steady) begin
			res_ch.ready <= 1'b1;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic int unsigned clamp_edge(input int unsigned v, input int unsigned hi);
		if (v < MIN_EDGE)
			return MIN_EDGE;
		return (v > hi) ? hi : v;
	endfunction

	// Shift one pixel through the line copies and window; queue the gradient it yields
	function automatic void predict_gradient(input logic [PIXEL_W-1:0] px);
		int unsigned        w, h, fr, c, r, i, j;
		int                 upper, lower;
		logic [PIXEL_W-1:0] above1, above2;
		grad_result_t       res;
		w = clamp_edge(width_reg, MAX_COLS);
		h = clamp_edge(height_reg, MAX_ROWS);
		fr = (first_row_reg == 0) ? 1 : first_row_reg;
		c = col_pos;
		r = row_pos;
		above1 = line_prev[c];
		above2 = line_prev2[c];
		line_prev2[c] = above1;
		line_prev[c]  = px;
		for (int k = 0; k < 6; k++)
			window_px[k] = window_px[k + 3];
		window_px[6] = above2;
		window_px[7] = above1;
		window_px[8] = px;
		// window_px[col*3 + row]: col 0 oldest, row 0 top
		if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
			i = r - 1;
			j = c - 1;
			if (i >= fr && i * w + j >= start_reg) begin
				upper = int'(window_px[0]) + CENTER_WEIGHT * int'(window_px[3]) + int'(window_px[6]);
				lower = int'(window_px[2]) + CENTER_WEIGHT * int'(window_px[5]) + int'(window_px[8]);
				res.gradient   = GRAD_W'(upper - lower);
				res.out_index  = INDEX_W'((i - 1) * w + (j - 1));
				res.frame_done = (r == h - 1 && c == w - 1);
				expected_results.push_back(res);
			end
		end
		// Raster advance, wrapping at the (possibly new) last position
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic logic [PIXEL_W-1:0] next_pixel(input pix_pattern_t pattern);
		case (pattern)
			PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			PAT_STRIPE:  return row_pos[0] ? 8'hAA : 8'h55;
			default:     return $urandom_range(0, 255);
		endcase
	endfunction

	// Offer one pixel, with random idle cycles ahead of it unless steady, until accepted
	task automatic send_pixel(input logic [PIXEL_W-1:0] px);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				pix_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		predict_gradient(px);
		items_sent++;
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_pixel($urandom_range(0, 255));
	endtask

	// Send pixels until the raster position is back at row 0, column 0
	task automatic finish_frame(input pix_pattern_t pattern);
		do
			send_pixel(next_pixel(pattern));
		while (col_pos != 0 || row_pos != 0);
	endtask

	// All results in, then a drain wait for pixels that give none
	task automatic wait_until_idle();
		pix_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg     = data[WIDTH_W-1:0];
			REG_IMAGE_HEIGHT: height_reg    = data[HEIGHT_W-1:0];
			REG_FIRST_ROW:    first_row_reg = data[ROW_W-1:0];
			REG_START_INDEX:  start_reg     = data[START_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_geometry(input logic [CFG_DATA_W-1:0] width_data,
		input logic [CFG_DATA_W-1:0] height_data, input logic [CFG_DATA_W-1:0] row_data,
		input logic [CFG_DATA_W-1:0] start_data);
		wait_until_idle();
		write_register(REG_IMAGE_WIDTH, width_data);
		write_register(REG_IMAGE_HEIGHT, height_data);
		write_register(REG_FIRST_ROW, row_data);
		write_register(REG_START_INDEX, start_data);
		cfg_we <= 1'b0;
	endtask

	// Reset geometry, then shrink mid-frame: once still inside, once past the new end
	task automatic test_reset_and_midframe();
		send_random(12);
		program_geometry(16, 4, 1, 0);
		send_random(40);
		program_geometry(8, 3, 1, 0);
		finish_frame(PAT_RANDOM);
	endtask

	// Full-scale positive and negative gradients, flat stripes, masked and clamped fields
	task automatic test_extremes();
		program_geometry(20'hFF803, 3, 0, 0);
		repeat (3) send_pixel(8'hFF);
		send_random(3);
		repeat (3) send_pixel(8'h00);
		repeat (3) send_pixel(8'h00);
		send_random(3);
		repeat (3) send_pixel(8'hFF);
		finish_frame(PAT_STRIPE);
	endtask

	// First-row and start-index gating, all-blocked frame, clamped small geometry
	task automatic test_gating();
		program_geometry(5, 6, 3, 17);
		finish_frame(PAT_RANDOM);
		program_geometry(4, 4, 10'h3FF, 20'hFFFFF);
		finish_frame(PAT_RANDOM);
		program_geometry(2, 0, 1, 4);
		finish_frame(PAT_EXTREME);
		program_geometry(1, 2, 1, 5);
		finish_frame(PAT_EXTREME);
	endtask

	// Oversized width runs past the old row end, then shrinks mid-frame past the new end
	task automatic test_max_width();
		program_geometry(20'h007FF, 3, 1, 0);
		send_random(40);
		program_geometry(6, 4, 1, 0);
		finish_frame(PAT_RANDOM);
	endtask

	// Oversized height keeps filtering deep rows, then shrinks mid-frame past the new end
	task automatic test_max_height();
		program_geometry(3, 20'h007FF, 1, 0);
		send_random(36);
		program_geometry(3, 5, 1, 0);
		finish_frame(PAT_RANDOM);
	endtask

	// Receiver holds off while pixels keep coming, so the pipeline fills and stalls input
	task automatic test_backpressure();
		program_geometry(10, 8, 1, 0);
		steady       = 1'b1;
		hold_request = HOLD_CYCLES;
		finish_frame(PAT_RANDOM);
		finish_frame(PAT_EXTREME);
		steady = 1'b0;
	endtask

	// Random whole frames with random gating, mostly small, some wider
	task automatic test_random_frames();
		int unsigned          first_item, w, h, fr, start;
		pix_pattern_t         pattern;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
			h = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0:       fr = 0;
				1:       fr = $urandom_range(0, 1023);
				default: fr = $urandom_range(1, clamp_edge(h, MAX_ROWS));
			endcase
			case ($urandom_range(0, 5))
				0:       start = $urandom_range(0, 20'hFFFFF);
				1, 2:    start = $urandom_range(0, clamp_edge(w, MAX_COLS) * clamp_edge(h, MAX_ROWS));
				default: start = 0;
			endcase
			case ($urandom_range(0, 5))
				0:       pattern = PAT_EXTREME;
				1:       pattern = PAT_STRIPE;
				default: pattern = PAT_RANDOM;
			endcase
			program_geometry(w, h, fr, start);
			// stretch with no idling on either side
			steady = (items_sent - first_item >= 350 && items_sent - first_item < 650);
			finish_frame(pattern);
		end
		steady = 1'b0;
	endtask

	initial begin
		pix_ch.valid  = 1'b0;
		pix_ch.pixel  = '0;
		res_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_IMAGE_WIDTH;
		cfg_data      = '0;
		arst_n        = 1'b0;
		width_reg     = WIDTH_RST;
		height_reg    = HEIGHT_RST;
		first_row_reg = ROW_RST;
		start_reg     = START_RST;
		col_pos       = 0;
		row_pos       = 0;
		items_sent    = 0;
		errors        = 0;
		cycle_count   = 0;
		hold_request  = 0;
		hold_left     = 0;
		steady        = 1'b0;
		foreach (window_px[k])
			window_px[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_midframe();
		test_extremes();
		test_gating();
		test_max_width();
		test_max_height();
		test_backpressure();
		test_random_frames();

		wait_until_idle();
		if (errors == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/svg_pkg.sv
rtl/svg_pix_if.sv
rtl/svg_res_if.sv
rtl/sobel_vertical_gradient_3x3.sv
tb/sv/tb.sv
